>>> rtl/core/ppe_pkg.sv
package ppe_pkg;

    // Default depth of the coefficient store.
    localparam int MAX_TERMS_DEF = 16;

    // Width of the time value that the wrap reduction iterates over.
    localparam int TIME_BITS = 31;

    // Q8.24 value of 1.0.
    localparam logic signed [31:0] ONE_Q24 = 32'sh0100_0000;

    // Configuration register indexes.
    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] REG_TERM_COUNT  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_WRAP_PERIOD = 2'd1;

    // Input item opcodes.
    localparam logic OP_WRITE = 1'b0;
    localparam logic OP_EVAL  = 1'b1;

    // Input transaction payload.
    typedef struct packed {
        logic               opcode;
        logic [3:0]         coef_index;
        logic signed [31:0] coef_value;
        logic signed [31:0] time_value;
    } in_item_t;

    // Output transaction payload.
    typedef struct packed {
        logic signed [31:0] poly_value;
        logic               saturated;
    } out_item_t;

    // Sequencer states.
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DIV,
        ST_MUL,
        ST_ACC,
        ST_POW,
        ST_DONE
    } ppe_state_t;

endpackage

>>> rtl/core/periodic_polynomial_evaluator.sv
// An evaluate transaction first reduces the time by the wrap period in a
// bit-serial remainder loop when the time is wrapped, then works through the
// terms on the single shared 32x32 multiplier. A new transaction is taken
// once the result is loaded.
// Reset clears the sequencer, sets term_count to 1 and wrap_period to 0, and
// clears the coefficient valid bits so that every coefficient reads as zero.
module periodic_polynomial_evaluator #(
    parameter int MAX_TERMS = ppe_pkg::MAX_TERMS_DEF
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           in_valid,
    output logic                           in_ready,
    input  ppe_pkg::in_item_t              in_data,
    output logic                           out_valid,
    input  logic                           out_ready,
    output ppe_pkg::out_item_t             out_data,
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [ppe_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [31:0]                    cfg_data
);

    import ppe_pkg::*;

    localparam int IDX_W = (MAX_TERMS > 1) ? $clog2(MAX_TERMS) : 1;
    localparam int CNT_W = $clog2(TIME_BITS);
    localparam logic signed [41:0] SAT_MAX = 42'sd2147483647;
    localparam logic signed [41:0] SAT_MIN = -42'sd2147483648;

    // Sequencer and control registers.
    ppe_state_t         state_reg;
    ppe_state_t         state_next;
    logic [4:0]         term_count_reg;
    logic [30:0]        wrap_reg;
    logic [IDX_W-1:0]   k_reg;
    logic [IDX_W-1:0]   last_reg;
    logic [CNT_W-1:0]   cnt_reg;
    logic               flag_reg;
    logic               out_valid_reg;
    out_item_t          out_data_reg;
    logic [MAX_TERMS-1:0] vld_reg;

    // Datapath registers.
    logic signed [31:0] x_reg;
    logic signed [31:0] pw_reg;
    logic signed [31:0] sum_reg;
    logic signed [63:0] prod_reg;
    logic [30:0]        rem_reg;
    logic [30:0]        dvd_reg;
    logic signed [31:0] coef_rd_reg;
    logic               vld_rd_reg;

    // Coefficient memory.
    logic signed [31:0] coef_mem [MAX_TERMS];

    // Combinational signals.
    logic               in_fire;
    logic               cfg_fire;
    logic               load_out;
    logic               eval_start;
    logic               need_wrap;
    logic               wr_en;
    logic [IDX_W-1:0]   wr_addr;
    logic [IDX_W-1:0]   rd_addr;
    logic [4:0]         n_eff;
    logic [31:0]        rem_shift;
    logic               rem_ge;
    logic [30:0]        rem_next;
    logic signed [31:0] coef_cur;
    logic signed [31:0] mul_a;
    logic signed [31:0] mul_b;
    logic signed [41:0] rnd_wide;
    logic signed [40:0] rnd_val;
    logic signed [41:0] acc_wide;
    logic signed [41:0] pow_wide;
    logic               acc_sat;
    logic               pow_sat;
    logic signed [31:0] acc_val;
    logic signed [31:0] pow_val;

    // Handshakes.
    assign in_fire    = in_valid && in_ready;
    assign cfg_fire   = cfg_valid && cfg_ready;
    assign cfg_ready  = 1'b1;
    assign out_valid  = out_valid_reg;
    assign out_data   = out_data_reg;
    assign eval_start = in_fire && (in_data.opcode == OP_EVAL);

    // The time is reduced only when a period is set and the time is non-negative and reaches it.
    assign need_wrap = (wrap_reg != 31'd0) && !in_data.time_value[31]
                       && (in_data.time_value[30:0] >= wrap_reg);

    // Effective number of terms: zero counts as one, and the count is clamped to the store depth.
    always_comb
    begin
        if (term_count_reg == 5'd0)
        begin
            n_eff = 5'd1;
        end
        else if (32'(term_count_reg) > MAX_TERMS)
        begin
            n_eff = 5'(MAX_TERMS);
        end
        else
        begin
            n_eff = term_count_reg;
        end
    end

    // One restoring remainder step per cycle.
    assign rem_shift = {rem_reg, dvd_reg[30]};
    assign rem_ge    = rem_shift >= {1'b0, wrap_reg};
    assign rem_next  = rem_ge ? 31'(rem_shift - {1'b0, wrap_reg}) : rem_shift[30:0];

    // Coefficient write and read addressing. While idle the read port points at
    // the constant term, so that it is ready for the first multiply.
    assign wr_en   = in_fire && (in_data.opcode == OP_WRITE)
                     && (32'(in_data.coef_index) < MAX_TERMS);
    assign wr_addr = IDX_W'(in_data.coef_index);
    assign rd_addr = (state_reg == ST_IDLE) ? '0 :
                     (state_reg == ST_POW) ? IDX_W'(k_reg + IDX_W'(1)) : k_reg;
    assign coef_cur = vld_rd_reg ? coef_rd_reg : 32'sd0;

    // Shared multiplier operand selection.
    assign mul_a = (state_reg == ST_MUL) ? coef_cur : pw_reg;
    assign mul_b = (state_reg == ST_MUL) ? pw_reg : x_reg;

    // Round half up: floor((p + 2^23) / 2^24).
    assign rnd_wide = {prod_reg[63], prod_reg[63:23]} + 42'sd1;
    assign rnd_val  = rnd_wide[41:1];

    // Saturating accumulate and saturating power update.
    assign acc_wide = {{10{sum_reg[31]}}, sum_reg} + {rnd_val[40], rnd_val};
    assign pow_wide = {rnd_val[40], rnd_val};
    assign acc_sat  = (acc_wide > SAT_MAX) || (acc_wide < SAT_MIN);
    assign pow_sat  = (pow_wide > SAT_MAX) || (pow_wide < SAT_MIN);
    assign acc_val  = (acc_wide > SAT_MAX) ? 32'sh7FFF_FFFF :
                      (acc_wide < SAT_MIN) ? 32'sh8000_0000 : acc_wide[31:0];
    assign pow_val  = (pow_wide > SAT_MAX) ? 32'sh7FFF_FFFF :
                      (pow_wide < SAT_MIN) ? 32'sh8000_0000 : pow_wide[31:0];

    // Next-state logic.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (eval_start)
                begin
                    state_next = need_wrap ? ST_DIV : ST_MUL;
                end
            end
            ST_DIV:
            begin
                if (cnt_reg == CNT_W'(0))
                begin
                    state_next = ST_MUL;
                end
            end
            ST_MUL:
            begin
                state_next = ST_ACC;
            end
            ST_ACC:
            begin
                state_next = (k_reg == last_reg) ? ST_DONE : ST_POW;
            end
            ST_POW:
            begin
                state_next = ST_MUL;
            end
            ST_DONE:
            begin
                if (load_out)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Sequencer outputs.
    always_comb
    begin
        in_ready = (state_reg == ST_IDLE);
        load_out = (state_reg == ST_DONE) && (!out_valid_reg || out_ready);
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            term_count_reg <= 5'd1;
            wrap_reg       <= 31'd0;
            k_reg          <= '0;
            last_reg       <= '0;
            cnt_reg        <= '0;
            flag_reg       <= 1'b0;
            out_valid_reg  <= 1'b0;
            vld_reg        <= '0;
        end
        else
        begin
            state_reg <= state_next;

            if (cfg_fire)
            begin
                unique case (cfg_index)
                    REG_TERM_COUNT:  term_count_reg <= cfg_data[4:0];
                    REG_WRAP_PERIOD: wrap_reg       <= cfg_data[30:0];
                    default:
                    begin
                    end
                endcase
            end

            if (wr_en)
            begin
                vld_reg[wr_addr] <= 1'b1;
            end

            if (eval_start)
            begin
                k_reg    <= '0;
                last_reg <= IDX_W'(n_eff - 5'd1);
                cnt_reg  <= CNT_W'(TIME_BITS - 1);
                flag_reg <= 1'b0;
            end
            if (state_reg == ST_DIV)
            begin
                cnt_reg <= cnt_reg - CNT_W'(1);
            end
            if (state_reg == ST_POW)
            begin
                k_reg <= IDX_W'(k_reg + IDX_W'(1));
            end
            if ((state_reg == ST_ACC && acc_sat) || (state_reg == ST_POW && pow_sat))
            begin
                flag_reg <= 1'b1;
            end

            if (load_out)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Datapath registers.
    always_ff @(posedge clk)
    begin
        if (eval_start)
        begin
            x_reg   <= in_data.time_value;
            dvd_reg <= in_data.time_value[30:0];
            rem_reg <= 31'd0;
            pw_reg  <= ONE_Q24;
            sum_reg <= 32'sd0;
        end
        if (state_reg == ST_DIV)
        begin
            rem_reg <= rem_next;
            dvd_reg <= {dvd_reg[29:0], 1'b0};
            if (cnt_reg == CNT_W'(0))
            begin
                x_reg <= $signed({1'b0, rem_next});
            end
        end
        if (state_reg == ST_MUL || state_reg == ST_ACC)
        begin
            prod_reg <= mul_a * mul_b;
        end
        if (state_reg == ST_ACC)
        begin
            sum_reg <= acc_val;
        end
        if (state_reg == ST_POW)
        begin
            pw_reg <= pow_val;
        end
        if (load_out)
        begin
            out_data_reg.poly_value <= sum_reg;
            out_data_reg.saturated  <= flag_reg;
        end
    end

    // Coefficient memory: one write port, one registered read port.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            coef_mem[wr_addr] <= in_data.coef_value;
        end
        coef_rd_reg <= coef_mem[rd_addr];
        vld_rd_reg  <= vld_reg[rd_addr];
    end

`ifndef SYNTHESIS
    // A result only appears after the sequencer has finished an evaluation.
    a_out_from_done: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(state_reg == ST_DONE))
        else $error("result presented without a finished evaluation");

    // The term counter never passes the last term in use.
    a_k_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != ST_IDLE) |-> (k_reg <= last_reg))
        else $error("term counter beyond last term");

    // The partial remainder stays below the wrap period.
    a_rem_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DIV) |-> (rem_reg < wrap_reg))
        else $error("partial remainder not below period");

    // A coefficient write transaction leaves the sequencer idle.
    a_write_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (in_fire && in_data.opcode == OP_WRITE) |=> (state_reg == ST_IDLE))
        else $error("coefficient write started an evaluation");
`endif

endmodule
